// File: sv/pxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_pkg: shared types and constants of the preamble cross-correlation peak detector
// Widths, preamble taps, peak-test ratios and pipeline depth.
// ----------------------------------------------------------------------------
package pxc_pkg;

	localparam int WINDOW_LEN  = 16;   // correlation window and power history depth
	localparam int SAMPLE_BITS = 16;   // significant low bits of each input part
	localparam int SMP_W       = 16;   // port width of one sample part
	localparam int COEF_W      = 13;   // signed tap width (largest |tap| is 2342)
	localparam int ACC_W       = 32;   // correlation partial sums (|sum| < 2^30)
	localparam int SHR         = 4;    // post-correlation scaling
	localparam int SQ_W        = 27;   // shifted sum part, signed
	localparam int POW_W       = 2 * SQ_W;
	localparam int RATIO_W     = 14;
	localparam int RATIO_HI    = 10000; // power * 10000 >= h * 9999
	localparam int RATIO_LO    = 9999;
	localparam int SCL_W       = POW_W + RATIO_W;
	localparam int TOT_W       = POW_W + $clog2(WINDOW_LEN);
	localparam int MEAN_NUM    = 13;   // 13 * sum(h) <= 160 * power
	localparam int MEAN_DEN    = 160;
	localparam int CMP_W       = TOT_W + 4;
	localparam int PIPE_N      = 6;    // register stages from accept to result

	typedef struct packed {
		logic signed [SMP_W-1:0] re;
		logic signed [SMP_W-1:0] im;
	} smp_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} acc_t;

	// power history entry with its pre-scaled copy (h * 9999)
	typedef struct packed {
		logic [POW_W-1:0] pw;
		logic [SCL_W-1:0] scl;
	} pwr_ent_t;

	localparam int PRE_RE [WINDOW_LEN] = '{
		753, -2162, -212, 2342, 1507, 2342, -212, -2162,
		753, 32, -1294, -212, 0, -212, -1294, 32};
	localparam int PRE_IM [WINDOW_LEN] = '{
		-753, -32, 1294, 212, 0, 212, 1294, -32,
		-753, 2162, 212, -2342, -1507, -2342, 212, 2162};

	// Tap for the sample that is j items old: the current sample takes tap 0,
	// a sample j items old takes tap WINDOW_LEN - j.
	function automatic logic signed [COEF_W-1:0] tap_re(input int j);
		return COEF_W'(PRE_RE[(WINDOW_LEN - j) % WINDOW_LEN]);
	endfunction

	function automatic logic signed [COEF_W-1:0] tap_im(input int j);
		return COEF_W'(PRE_IM[(WINDOW_LEN - j) % WINDOW_LEN]);
	endfunction

endpackage

// File: sv/pxc_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_sample_if: baseband sample channel
// valid/ready handshake carrying one complex sample per transaction.
// ----------------------------------------------------------------------------
interface pxc_sample_if import pxc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_re;
	logic signed [SMP_W-1:0] sample_im;

	modport source (output valid, output sample_re, output sample_im, input ready);
	modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

// File: sv/pxc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_result_if: correlation power / peak flag channel
// valid/ready handshake carrying one power value and its peak flag.
// ----------------------------------------------------------------------------
interface pxc_result_if import pxc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POW_W-1:0] corr_power;
	logic             is_peak;

	modport source (output valid, output corr_power, output is_peak, input ready);
	modport sink (input valid, input corr_power, input is_peak, output ready);
endinterface

// File: sv/preamble_xcorr_peak_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preamble_xcorr_peak_detector: short-preamble cross-correlation peak detector
// Correlates incoming samples with the 16-tap short preamble and flags peaks.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                         transaction
//  samples   in   sample_re[15:0], sample_im[15:0] valid & ready
//  results   out  corr_power[53:0], is_peak         valid & ready
//
//  One sample in, one result out, at up to one transaction per cycle.
//  Six register stages (s1 .. s6 below); s1 loads at the accepting edge, and
//  result valid rises when the item is loaded into s6.
//  Stages advance independently: a bubble is squeezed out, and a stalled
//  result only holds back stages that are full behind it.
//  Reset clears correlator partial sums, power history, running total and
//  valid bits at once; no clearing pass, samples are taken right after reset.
//
//  s1  input register, sign extension from SAMPLE_BITS
//  s2  transposed correlator: a row of 16 cells, each one complex tap;
//      cell 0 holds the finished sum
//  s3  shift by 4 (floor), squares of both parts
//  s4  power = re^2 + im^2
//  s5  power history shifts (row of 16 cells with pre-scaled h * 9999),
//      running total updated, power scaled by 10000 and 160
//  s6  all ratio checks and the mean check, output register
// ----------------------------------------------------------------------------
module preamble_xcorr_peak_detector import pxc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pxc_sample_if.sink   samples,
	pxc_result_if.source results
);

	function automatic logic signed [SMP_W-1:0] sext(input logic [SMP_W-1:0] v);
		return SMP_W'(signed'(v[SAMPLE_BITS-1:0]));
	endfunction

	// ---------------- handshake / stage control ----------------
	logic [PIPE_N:1] vld_q;
	logic [PIPE_N:1] vld_in;
	logic [PIPE_N:1] en;
	logic [PIPE_N:1] ld;

	assign vld_in = {vld_q[PIPE_N-1:1], samples.valid};

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		en[PIPE_N] = !vld_q[PIPE_N] || results.ready;
		for (int k = PIPE_N - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign ld            = en & vld_in;
	assign samples.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= PIPE_N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// ---------------- s1: input register ----------------
	smp_t x_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			x_s1.re <= sext(samples.sample_re);
			x_s1.im <= sext(samples.sample_im);
		end
	end

	// ---------------- s2: correlator cell row ----------------
	// cell j holds the sum of taps j..15 applied to the matching older samples
	acc_t corr [WINDOW_LEN];

	for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_corr
		if (g == WINDOW_LEN - 1) begin : g_tail
			pxc_corr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ld[2]),
				.x      (x_s1),
				.c_re   (tap_re(g)),
				.c_im   (tap_im(g)),
				.sum_in ('0),
				.sum    (corr[g])
			);
		end else begin : g_body
			pxc_corr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ld[2]),
				.x      (x_s1),
				.c_re   (tap_re(g)),
				.c_im   (tap_im(g)),
				.sum_in (corr[g+1]),
				.sum    (corr[g])
			);
		end
	end

	// ---------------- s3: shift and square ----------------
	logic signed [SQ_W-1:0]   sr_re, sr_im;
	logic signed [POW_W-1:0]  mul_re, mul_im;
	logic        [POW_W-1:0]  sq_re_s3, sq_im_s3;

	// |sum| < 2^30, so dropping the top bit keeps the value; >>4 rounds down
	assign sr_re  = signed'(corr[0].re[SQ_W+SHR-1:SHR]);
	assign sr_im  = signed'(corr[0].im[SQ_W+SHR-1:SHR]);
	assign mul_re = sr_re * sr_re;
	assign mul_im = sr_im * sr_im;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			sq_re_s3 <= unsigned'(mul_re);
			sq_im_s3 <= unsigned'(mul_im);
		end
	end

	// ---------------- s4: power ----------------
	logic [POW_W-1:0] power_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			power_s4 <= sq_re_s3 + sq_im_s3;
		end
	end

	// ---------------- s5: power history row ----------------
	pwr_ent_t               head;
	pwr_ent_t               ring [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]  ok_vec;
	logic [TOT_W-1:0]       total_q;
	logic [POW_W-1:0]       power_s5;
	logic [SCL_W-1:0]       p10000_s5;
	logic [CMP_W-1:0]       p160_s5;

	assign head.pw  = power_s4;
	assign head.scl = SCL_W'(power_s4) * SCL_W'(RATIO_LO);

	for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_pwr
		if (g == 0) begin : g_head
			pxc_power_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ld[5]),
				.ent_in (head),
				.lim    (p10000_s5),
				.ent    (ring[g]),
				.ok     (ok_vec[g])
			);
		end else begin : g_body
			pxc_power_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ld[5]),
				.ent_in (ring[g-1]),
				.lim    (p10000_s5),
				.ent    (ring[g]),
				.ok     (ok_vec[g])
			);
		end
	end

	// running total of the history: newest in, oldest out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ld[5]) begin
			total_q <= total_q + TOT_W'(power_s4) - TOT_W'(ring[WINDOW_LEN-1].pw);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			power_s5  <= power_s4;
			p10000_s5 <= SCL_W'(power_s4) * SCL_W'(RATIO_HI);
			p160_s5   <= CMP_W'(power_s4) * CMP_W'(MEAN_DEN);
		end
	end

	// ---------------- s6: peak decision, output register ----------------
	// The history does not move between s5 load and s6 load of the same item:
	// it shifts only when s5 is free, i.e. when s6 takes s5's content.
	logic [CMP_W-1:0] tot13;
	logic             peak;
	logic [POW_W-1:0] corr_power_s6;
	logic             is_peak_s6;

	assign tot13 = CMP_W'(total_q) * CMP_W'(MEAN_NUM);
	assign peak  = (&ok_vec) && (tot13 <= p160_s5);

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			corr_power_s6 <= power_s5;
			is_peak_s6    <= peak;
		end
	end

	assign results.valid      = vld_q[PIPE_N];
	assign results.corr_power = corr_power_s6;
	assign results.is_peak    = is_peak_s6;

endmodule

// File: sv/pxc_corr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_corr_cell: one tap of the transposed correlator
// Multiplies the broadcast sample by a fixed tap and adds the neighbor's sum.
// ----------------------------------------------------------------------------
module pxc_corr_cell import pxc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift,
	input  smp_t                     x,
	input  logic signed [COEF_W-1:0] c_re,
	input  logic signed [COEF_W-1:0] c_im,
	input  acc_t                     sum_in,
	output acc_t                     sum
);

	logic signed [SMP_W+COEF_W-1:0] p_rr, p_ii, p_ri, p_ir;
	acc_t                           sum_d;

	// plain complex product, no conjugate
	assign p_rr = x.re * c_re;
	assign p_ii = x.im * c_im;
	assign p_ri = x.re * c_im;
	assign p_ir = x.im * c_re;

	assign sum_d.re = sum_in.re + ACC_W'(p_rr) - ACC_W'(p_ii);
	assign sum_d.im = sum_in.im + ACC_W'(p_ri) + ACC_W'(p_ir);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum <= '0;
		end else if (shift) begin
			sum <= sum_d;
		end
	end

endmodule

// File: sv/pxc_power_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_power_cell: one slot of the power history
// Holds a power and its scaled copy, passes both on, checks the ratio bound.
// ----------------------------------------------------------------------------
module pxc_power_cell import pxc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  pwr_ent_t         ent_in,
	input  logic [SCL_W-1:0] lim,
	output pwr_ent_t         ent,
	output logic             ok
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent <= '0;
		end else if (shift) begin
			ent <= ent_in;
		end
	end

	// h * 9999 <= power * 10000
	assign ok = (ent.scl <= lim);

endmodule

// File: sv/pxc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxc_checker: port-level checks of the peak detector
// Tracks transactions in flight and checks flow behavior at the ports.
// ----------------------------------------------------------------------------
module pxc_checker import pxc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [POW_W-1:0] corr_power,
	input logic             is_peak
);

	localparam int PEND_W = $clog2(PIPE_N + 2);

	logic              in_acc, out_acc;
	logic [PEND_W-1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_W'(in_acc) - PEND_W'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(corr_power) && $stable(is_peak))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without a sample in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(PIPE_N))
		else $error("more samples in flight than pipeline stages");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

endmodule

bind preamble_xcorr_peak_detector pxc_checker u_pxc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.corr_power (results.corr_power),
	.is_peak    (results.is_peak)
);
